FILE: design/lpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line point generator package
// Shared codes for the item kind and the per-axis step direction.
// ----------------------------------------------------------------------------
package lpg_pkg;

   // What an input item asks for
   typedef enum logic {
      KIND_START = 1'b0,
      KIND_STEP  = 1'b1
   } kind_type;

   // Step direction of one axis
   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_INC  = 2'd1,
      DIR_DEC  = 2'd3
   } dir_type;

endpackage

FILE: design/lpg_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line point generator input register
// Holds one accepted request until the engine consumes it.
// ----------------------------------------------------------------------------
module lpg_in_reg #(
   parameter int COORD_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  lpg_pkg::kind_type     req_kind,
   input  logic [COORD_BITS-1:0] req_x_begin,
   input  logic [COORD_BITS-1:0] req_y_begin,
   input  logic [COORD_BITS-1:0] req_x_finish,
   input  logic [COORD_BITS-1:0] req_y_finish,
   input  logic                  advance,
   output logic                  stage_valid,
   output lpg_pkg::kind_type     stage_kind,
   output logic [COORD_BITS-1:0] stage_x_begin,
   output logic [COORD_BITS-1:0] stage_y_begin,
   output logic [COORD_BITS-1:0] stage_x_finish,
   output logic [COORD_BITS-1:0] stage_y_finish
);
   import lpg_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic                  load;
   kind_type              kind_ff;
   logic [COORD_BITS-1:0] xb_ff;
   logic [COORD_BITS-1:0] yb_ff;
   logic [COORD_BITS-1:0] xf_ff;
   logic [COORD_BITS-1:0] yf_ff;

   // Take a new transfer whenever the held one leaves this cycle
   assign req_tready = !valid_ff || advance;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= req_kind;
         xb_ff   <= req_x_begin;
         yb_ff   <= req_y_begin;
         xf_ff   <= req_x_finish;
         yf_ff   <= req_y_finish;
      end
   end

   assign stage_valid    = valid_ff;
   assign stage_kind     = kind_ff;
   assign stage_x_begin  = xb_ff;
   assign stage_y_begin  = yb_ff;
   assign stage_x_finish = xf_ff;
   assign stage_y_finish = yf_ff;

endmodule

FILE: design/lpg_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line point generator engine
// Line state and the per-item step: setup on start, error update on step.
// ----------------------------------------------------------------------------
module lpg_engine #(
   parameter int COORD_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  lpg_pkg::kind_type     kind,
   input  logic [COORD_BITS-1:0] x_begin,
   input  logic [COORD_BITS-1:0] y_begin,
   input  logic [COORD_BITS-1:0] x_finish,
   input  logic [COORD_BITS-1:0] y_finish,
   output logic                  res_valid,
   output logic [COORD_BITS-1:0] res_px,
   output logic [COORD_BITS-1:0] res_py,
   output logic                  res_last
);
   import lpg_pkg::*;

   localparam int ERR_BITS = COORD_BITS + 1;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [ERR_BITS-1:0]   err_type;

   coord_type cur_col_ff,  cur_col_in;
   coord_type cur_row_ff,  cur_row_in;
   err_type   col_err_ff,  col_err_in;
   err_type   row_err_ff,  row_err_in;
   coord_type abs_dcol_ff, abs_dcol_in;
   coord_type abs_drow_ff, abs_drow_in;
   dir_type   col_dir_ff,  col_dir_in;
   dir_type   row_dir_ff,  row_dir_in;
   coord_type span_ff,     span_in;
   err_type   left_ff,     left_in;
   logic      busy_ff,     busy_in;

   coord_type dcol_new, drow_new, span_new;
   dir_type   cdir_new, rdir_new;
   err_type   col_sum, row_sum, left_dec;
   logic      col_hit, row_hit, last_step, is_start;

   function automatic coord_type move_coord(input coord_type c, input dir_type d);
      coord_type r;
      case (d)
         DIR_INC: r = c + 1'b1;
         DIR_DEC: r = c - 1'b1;
         default: r = c;
      endcase
      return r;
   endfunction

   assign is_start = (kind == KIND_START);

   // Start setup: magnitudes, directions and span
   always_comb begin
      if (x_finish > x_begin) begin
         dcol_new = x_finish - x_begin;
         cdir_new = DIR_INC;
      end else if (x_finish == x_begin) begin
         dcol_new = '0;
         cdir_new = DIR_NONE;
      end else begin
         dcol_new = x_begin - x_finish;
         cdir_new = DIR_DEC;
      end
      if (y_finish > y_begin) begin
         drow_new = y_finish - y_begin;
         rdir_new = DIR_INC;
      end else if (y_finish == y_begin) begin
         drow_new = '0;
         rdir_new = DIR_NONE;
      end else begin
         drow_new = y_begin - y_finish;
         rdir_new = DIR_DEC;
      end
      span_new = (dcol_new > drow_new) ? dcol_new : drow_new;
   end

   // Step: accumulate, and move an axis once its error passes the span
   assign col_sum   = col_err_ff + err_type'(abs_dcol_ff);
   assign row_sum   = row_err_ff + err_type'(abs_drow_ff);
   assign col_hit   = col_sum > err_type'(span_ff);
   assign row_hit   = row_sum > err_type'(span_ff);
   assign left_dec  = left_ff - 1'b1;
   assign last_step = (left_dec == '0);

   assign res_valid = is_start || busy_ff;
   assign res_px    = is_start ? x_begin : cur_col_ff;
   assign res_py    = is_start ? y_begin : cur_row_ff;
   assign res_last  = !is_start && last_step;

   always_comb begin
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      col_err_in  = col_err_ff;
      row_err_in  = row_err_ff;
      abs_dcol_in = abs_dcol_ff;
      abs_drow_in = abs_drow_ff;
      col_dir_in  = col_dir_ff;
      row_dir_in  = row_dir_ff;
      span_in     = span_ff;
      left_in     = left_ff;
      busy_in     = busy_ff;
      if (fire && is_start) begin
         // First advance from zero error never moves: each delta is at most the span
         cur_col_in  = x_begin;
         cur_row_in  = y_begin;
         col_err_in  = err_type'(dcol_new);
         row_err_in  = err_type'(drow_new);
         abs_dcol_in = dcol_new;
         abs_drow_in = drow_new;
         col_dir_in  = cdir_new;
         row_dir_in  = rdir_new;
         span_in     = span_new;
         left_in     = err_type'(span_new) + 1'b1;
         busy_in     = 1'b1;
      end else if (fire && busy_ff) begin
         col_err_in = col_hit ? col_sum - err_type'(span_ff) : col_sum;
         row_err_in = row_hit ? row_sum - err_type'(span_ff) : row_sum;
         cur_col_in = col_hit ? move_coord(cur_col_ff, col_dir_ff) : cur_col_ff;
         cur_row_in = row_hit ? move_coord(cur_row_ff, row_dir_ff) : cur_row_ff;
         left_in    = left_dec;
         busy_in    = !last_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_col_ff  <= cur_col_in;
      cur_row_ff  <= cur_row_in;
      col_err_ff  <= col_err_in;
      row_err_ff  <= row_err_in;
      abs_dcol_ff <= abs_dcol_in;
      abs_drow_ff <= abs_drow_in;
      col_dir_ff  <= col_dir_in;
      row_dir_ff  <= row_dir_in;
      span_ff     <= span_in;
      left_ff     <= left_in;
   end

endmodule

FILE: design/lpg_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line point generator output register
// Holds one result point until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module lpg_out_reg #(
   parameter int COORD_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [COORD_BITS-1:0] in_px,
   input  logic [COORD_BITS-1:0] in_py,
   input  logic                  in_last,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [COORD_BITS-1:0] rsp_px,
   output logic [COORD_BITS-1:0] rsp_py,
   output logic                  rsp_last
);
   logic                  valid_ff, valid_in;
   logic [COORD_BITS-1:0] px_ff, py_ff;
   logic                  last_ff;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff   <= in_px;
         py_ff   <= in_py;
         last_ff <= in_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_px     = px_ff;
   assign rsp_py     = py_ff;
   assign rsp_last   = last_ff;

endmodule

FILE: design/line_point_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line point generator
// Rasterizes a straight line one point per request, Bresenham style.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  req_    | in        | tuser: kind; tdata: x_begin, y_begin, x_finish, y_finish
//  rsp_    | out       | tdata: px, py; tlast: final point of the line
//
//  One request per clock is accepted while the result register is free; its
//  point passes the input register, then the result register, before it is
//  offered as a result transfer.
//  The step is one add, compare and subtract per axis on the error registers.
//  Synchronous reset empties both registers and ends any active line.
//  A stalled result holds; the input register still takes one more request.
// ----------------------------------------------------------------------------
module line_point_generator_top #(
   parameter int COORD_BITS = 10,
   localparam int REQ_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // x_begin, y_begin, x_finish, y_finish
   input  logic                     req_tuser,  // kind
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // px, py
   output logic                     rsp_tlast   // final_point
);
   import lpg_pkg::*;

   logic                  stage_valid, advance, out_free, res_valid, load;
   kind_type              stage_kind;
   logic [COORD_BITS-1:0] stage_xb, stage_yb, stage_xf, stage_yf;
   logic [COORD_BITS-1:0] res_px, res_py, out_px, out_py;
   logic                  res_last;

   lpg_in_reg #(.COORD_BITS(COORD_BITS)) u_in_reg (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_kind       (kind_type'(req_tuser)),
      .req_x_begin    (req_tdata[COORD_BITS-1:0]),
      .req_y_begin    (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .req_x_finish   (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .req_y_finish   (req_tdata[4*COORD_BITS-1:3*COORD_BITS]),
      .advance        (advance),
      .stage_valid    (stage_valid),
      .stage_kind     (stage_kind),
      .stage_x_begin  (stage_xb),
      .stage_y_begin  (stage_yb),
      .stage_x_finish (stage_xf),
      .stage_y_finish (stage_yf)
   );

   // Advance the held request when the result register can take its point
   assign advance = stage_valid && out_free;
   assign load    = advance && res_valid;

   lpg_engine #(.COORD_BITS(COORD_BITS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .kind      (stage_kind),
      .x_begin   (stage_xb),
      .y_begin   (stage_yb),
      .x_finish  (stage_xf),
      .y_finish  (stage_yf),
      .res_valid (res_valid),
      .res_px    (res_px),
      .res_py    (res_py),
      .res_last  (res_last)
   );

   lpg_out_reg #(.COORD_BITS(COORD_BITS)) u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .in_px      (res_px),
      .in_py      (res_py),
      .in_last    (res_last),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_px     (out_px),
      .rsp_py     (out_py),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_BITS'({out_py, out_px});

endmodule

FILE: design/lpg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line point generator checker
// Port-level checks on the result channel and on input flow control.
// ----------------------------------------------------------------------------
module lpg_checker #(
   parameter int COORD_BITS = 10,
   localparam int RSP_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                     rsp_tlast
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result payload changed while stalled");

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // A free result side never blocks requests
   a_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("request side stalled with result side free");

endmodule

bind line_point_generator_top lpg_checker #(.COORD_BITS(COORD_BITS)) u_lpg_checker (.*);

FILE: test/tb_line_point_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line point generator testbench
// Drives start and step requests, with idle gaps and stalls on both channels,
// predicts every point of each line in step with the accepted requests and
// checks the emitted points in order.
// ----------------------------------------------------------------------------
module tb_line_point_generator_top;
   import lpg_pkg::*;

   localparam int COORD_BITS    = 10;
   localparam int REQ_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int COORD_TOP     = (1 << COORD_BITS) - 1;
   localparam int NEAR_REACH    = 24;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COORD_BITS:0]   acc_type;

   typedef struct packed {
      coord_type px;
      coord_type py;
      logic      last;
   } point_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;   // x_begin, y_begin, x_finish, y_finish
   logic                     req_tuser;   // kind
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // px, py
   logic                     rsp_tlast;   // final_point

   // Rasterizer state as the testbench tracks it
   coord_type cur_col, cur_row, abs_dcol, abs_drow, span;
   acc_type   col_err, row_err, points_left;
   dir_type   col_dir, row_dir;
   logic      line_active;

   point_type pending_points[$];
   int        errors;
   int        send_idle_pct;
   int        recv_idle_pct;
   int        recv_hold;

   line_point_generator_top #(
      .COORD_BITS(COORD_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic coord_type move_coord(coord_type c, dir_type d);
      case (d)
         DIR_INC: return c + 1'b1;
         DIR_DEC: return c - 1'b1;
         default: return c;
      endcase
   endfunction

   task automatic axis_setup(input coord_type a, input coord_type b,
                             output coord_type mag, output dir_type dir);
      if (b > a) begin
         mag = b - a;
         dir = DIR_INC;
      end else if (b == a) begin
         mag = '0;
         dir = DIR_NONE;
      end else begin
         mag = a - b;
         dir = DIR_DEC;
      end
   endtask

   // Work out the point an accepted request emits, then advance the line
   task automatic trace_line_point(input kind_type kind, input coord_type xb,
                                   input coord_type yb, input coord_type xf,
                                   input coord_type yf);
      logic final_pt;
      final_pt = 1'b0;
      if (kind == KIND_START) begin
         axis_setup(xb, xf, abs_dcol, col_dir);
         axis_setup(yb, yf, abs_drow, row_dir);
         span        = (abs_dcol > abs_drow) ? abs_dcol : abs_drow;
         cur_col     = xb;
         cur_row     = yb;
         col_err     = '0;
         row_err     = '0;
         points_left = {1'b0, span} + 1'b1;
         line_active = 1'b1;
      end else begin
         // a step with no line active emits nothing
         if (!line_active) return;
         points_left = points_left - 1'b1;
         if (points_left == '0) begin
            final_pt    = 1'b1;
            line_active = 1'b0;
         end
      end
      pending_points.push_back('{px: cur_col, py: cur_row, last: final_pt});
      col_err = col_err + abs_dcol;
      row_err = row_err + abs_drow;
      if (col_err > span) begin
         col_err = col_err - span;
         cur_col = move_coord(cur_col, col_dir);
      end
      if (row_err > span) begin
         row_err = row_err - span;
         cur_row = move_coord(cur_row, row_dir);
      end
   endtask

   function automatic coord_type rand_coord();
      return coord_type'($urandom);
   endfunction

   function automatic coord_type near_coord(coord_type c);
      int v;
      v = int'(c) + int'($urandom_range(2 * NEAR_REACH)) - NEAR_REACH;
      if (v < 0) v = 0;
      if (v > COORD_TOP) v = COORD_TOP;
      return coord_type'(v);
   endfunction

   task automatic send_item(input kind_type kind, input coord_type xb, input coord_type yb,
                            input coord_type xf, input coord_type yf);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {yf, xf, yb, xb};
      do @(posedge clock); while (!req_tready);
      trace_line_point(kind, xb, yb, xf, yf);
   endtask

   task automatic send_steps(input int n);
      repeat (n) send_item(KIND_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
   endtask

   task automatic send_line(input coord_type xb, input coord_type yb, input coord_type xf,
                            input coord_type yf, input int steps);
      send_item(KIND_START, xb, yb, xf, yf);
      send_steps(steps);
   endtask

   task automatic test_step_while_idle();
      send_steps(1);
   endtask

   task automatic test_equal_endpoints();
      // second step falls after the final point and emits nothing
      send_line(coord_type'(5), coord_type'(5), coord_type'(5), coord_type'(5), 2);
   endtask

   task automatic test_extreme_endpoints();
      send_line('0, '0, '1, '1, 3);
      // restart while the line is still active
      send_line('1, '1, '0, '0, 2);
      send_line('0, '1, '1, '0, 1);
   endtask

   task automatic test_short_lines();
      send_line(coord_type'(10), coord_type'(10), coord_type'(13), coord_type'(8), 4);
      send_line(coord_type'(100), coord_type'(50), coord_type'(96), coord_type'(50), 5);
   endtask

   task automatic test_random_lines(input int n_items);
      int        sent;
      int        steps;
      int        pick;
      int        reach;
      logic      far;
      coord_type xb, yb, xf, yf;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 5) begin
            // stray step, mid-line or while idle
            send_steps(1);
            sent++;
         end else begin
            xb  = rand_coord();
            yb  = rand_coord();
            far = ($urandom_range(99) < 8);
            if (far) begin
               xf = rand_coord();
               yf = rand_coord();
            end else begin
               xf = near_coord(xb);
               yf = near_coord(yb);
            end
            reach = (xf > xb) ? int'(xf - xb) : int'(xb - xf);
            if (((yf > yb) ? int'(yf - yb) : int'(yb - yf)) > reach)
               reach = (yf > yb) ? int'(yf - yb) : int'(yb - yf);
            pick = $urandom_range(99);
            if (far)
               steps = $urandom_range(12);
            else if (pick < 15)
               steps = $urandom_range(reach);
            else if (pick < 25)
               steps = reach + 1 + $urandom_range(1, 3);
            else
               steps = reach + 1;
            send_line(xb, yb, xf, yf, steps);
            sent += 1 + steps;
         end
      end
   endtask

   task automatic test_backpressure();
      // hold the result side off long enough that the request side stalls
      recv_hold = 300;
      send_line(coord_type'(200), coord_type'(300), coord_type'(240), coord_type'(277), 41);
   endtask

   task automatic test_long_line();
      send_line('0, rand_coord(), '1, rand_coord(), COORD_TOP + 1);
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (recv_hold > 0) begin
            rsp_tready <= 1'b0;
            recv_hold = recv_hold - 1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_points
      point_type exp_pt;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_points.size() == 0) begin
            errors++;
            $display("%0t: unexpected point px=%0d py=%0d last=%0b", $time,
                     rsp_tdata[COORD_BITS-1:0], rsp_tdata[2*COORD_BITS-1:COORD_BITS],
                     rsp_tlast);
         end else begin
            exp_pt = pending_points.pop_front();
            if (rsp_tdata[COORD_BITS-1:0] !== exp_pt.px ||
                rsp_tdata[2*COORD_BITS-1:COORD_BITS] !== exp_pt.py ||
                rsp_tlast !== exp_pt.last) begin
               errors++;
               $display({"%0t: point mismatch expected px=%0d py=%0d last=%0b, ",
                         "got px=%0d py=%0d last=%0b"},
                        $time, exp_pt.px, exp_pt.py, exp_pt.last,
                        rsp_tdata[COORD_BITS-1:0], rsp_tdata[2*COORD_BITS-1:COORD_BITS],
                        rsp_tlast);
            end
         end
      end
   end

   initial begin
      errors        = 0;
      recv_hold     = 0;
      send_idle_pct = 7;
      recv_idle_pct = 60;
      cur_col       = '0;
      cur_row       = '0;
      abs_dcol      = '0;
      abs_drow      = '0;
      span          = '0;
      col_err       = '0;
      row_err       = '0;
      points_left   = '0;
      col_dir       = DIR_NONE;
      row_dir       = DIR_NONE;
      line_active   = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tuser     = 1'b0;
      req_tdata     = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_step_while_idle();
      test_equal_endpoints();
      test_extreme_endpoints();
      test_short_lines();
      test_random_lines(30);

      send_idle_pct = 60;
      recv_idle_pct = 7;
      test_random_lines(30);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random_lines(30);
      test_long_line();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: line_point_generator_top.f
design/lpg_pkg.sv
design/lpg_in_reg.sv
design/lpg_engine.sv
design/lpg_out_reg.sv
design/line_point_generator_top.sv
design/lpg_checker.sv
test/tb_line_point_generator_top.sv
